// File: hw/rtl/ilsp_pkg.sv
package ilsp_pkg;

    localparam logic [7:0] CH_LF  = 8'h0A;
    localparam logic [7:0] CH_CR  = 8'h0D;
    localparam logic [7:0] CH_LBR = 8'h5B;
    localparam logic [7:0] CH_RBR = 8'h5D;
    localparam logic [7:0] CH_EQ  = 8'h3D;

    localparam logic CMD_TEXT = 1'b0;
    localparam logic CMD_END  = 1'b1;

    localparam logic [2:0] ROLE_STRUCT  = 3'd0;
    localparam logic [2:0] ROLE_SECTION = 3'd1;
    localparam logic [2:0] ROLE_KEY     = 3'd2;
    localparam logic [2:0] ROLE_VALUE   = 3'd3;
    localparam logic [2:0] ROLE_VERDICT = 3'd4;

    localparam logic [1:0] VERDICT_BLANK   = 2'd0;
    localparam logic [1:0] VERDICT_SECTION = 2'd1;
    localparam logic [1:0] VERDICT_KV      = 2'd2;
    localparam logic [1:0] VERDICT_ERROR   = 2'd3;

    localparam logic [2:0] ERR_NONE        = 3'd0;
    localparam logic [2:0] ERR_TOO_LONG    = 3'd1;
    localparam logic [2:0] ERR_NO_RBR      = 3'd2;
    localparam logic [2:0] ERR_BAD_SECTION = 3'd3;
    localparam logic [2:0] ERR_NO_EQ       = 3'd4;
    localparam logic [2:0] ERR_BAD_KEY     = 3'd5;
    localparam logic [2:0] ERR_EQ_IN_VALUE = 3'd6;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = 2;
    localparam int QCNT_W      = 3;

    typedef struct packed {
        logic [2:0]  role;
        logic [7:0]  text_byte;
        logic [1:0]  verdict;
        logic [2:0]  error_code;
        logic [7:0]  error_column;
        logic [15:0] line_number;
        logic        end_of_input;
        logic        last;
    } result_t;

    // up to two results per item, first one in rec0
    typedef struct packed {
        logic [1:0] count;
        result_t    rec0;
        result_t    rec1;
    } push_t;

    function automatic logic is_alnum(input logic [7:0] c);
        is_alnum = (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h5A) ||
                   (c >= 8'h61 && c <= 8'h7A);
    endfunction

    function automatic logic is_ws(input logic [7:0] c);
        is_ws = (c == 8'h20) || (c >= 8'h09 && c <= 8'h0D);
    endfunction

endpackage

// File: hw/rtl/ilsp_core.sv
module ilsp_core #(
    parameter int MAX_COLUMNS = 256
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              accept,
    input  logic              cmd,
    input  logic [7:0]        ch,
    output ilsp_pkg::push_t   push
);

    localparam int CW = $clog2(MAX_COLUMNS + 1);

    logic [7:0]    held_byte_reg, held_byte_next;
    logic          held_valid_reg, held_valid_next;
    logic [CW-1:0] col_reg, col_next;
    logic          ws_reg, ws_next;
    logic          sec_reg, sec_next;
    logic          eq_reg, eq_next;
    logic          rbr_reg, rbr_next;
    logic          bad_v_reg, bad_v_next;
    logic [CW-1:0] bad_col_reg, bad_col_next;
    logic          veq_v_reg, veq_v_next;
    logic [CW-1:0] veq_col_reg, veq_col_next;
    logic [15:0]   line_index_reg, line_index_next;
    logic          halted_reg, halted_next;

    // state after committing the held byte
    logic [CW-1:0] cm_col, cm_bad_col, cm_veq_col;
    logic          cm_ws, cm_sec, cm_eq, cm_rbr, cm_bad_v, cm_veq_v;
    logic [2:0]    cm_role;
    logic          cand_a, cand_b;

    logic          do_finish, do_commit;
    logic [CW-1:0] p_col, p_bad_col, p_veq_col;
    logic          p_ws, p_sec, p_eq, p_rbr, p_bad_v, p_veq_v;

    logic [1:0]    fin_verdict;
    logic [2:0]    fin_err;
    logic [CW-1:0] fin_col;
    logic [CW+7:0] fin_col_ext;

    ilsp_pkg::result_t commit_rec, fin_rec;

    always_comb
    begin
        cm_col     = (col_reg < CW'(MAX_COLUMNS)) ? col_reg + CW'(1) : col_reg;
        cm_ws      = ws_reg & ilsp_pkg::is_ws(held_byte_reg);
        cm_sec     = sec_reg | ((col_reg == '0) && (held_byte_reg == ilsp_pkg::CH_LBR));
        cm_eq      = eq_reg;
        cm_rbr     = rbr_reg;
        cm_bad_v   = bad_v_reg;
        cm_bad_col = bad_col_reg;
        cm_veq_v   = veq_v_reg;
        cm_veq_col = veq_col_reg;
        cand_a     = 1'b0;
        cand_b     = 1'b0;
        if (cm_sec)
        begin
            // a ']' that is not the last byte counts against the name
            cand_a = (col_reg >= CW'(2)) && rbr_reg;
            if ((col_reg == '0) || (held_byte_reg == ilsp_pkg::CH_RBR))
            begin
                cm_role = ilsp_pkg::ROLE_STRUCT;
            end
            else
            begin
                cm_role = ilsp_pkg::ROLE_SECTION;
                cand_b  = !ilsp_pkg::is_alnum(held_byte_reg);
            end
            cm_rbr = (held_byte_reg == ilsp_pkg::CH_RBR);
        end
        else if (!eq_reg)
        begin
            if (held_byte_reg == ilsp_pkg::CH_EQ)
            begin
                cm_eq   = 1'b1;
                cm_role = ilsp_pkg::ROLE_STRUCT;
            end
            else
            begin
                cm_role = ilsp_pkg::ROLE_KEY;
                cand_b  = !ilsp_pkg::is_alnum(held_byte_reg);
            end
        end
        else
        begin
            cm_role = ilsp_pkg::ROLE_VALUE;
            if ((held_byte_reg == ilsp_pkg::CH_EQ) && !veq_v_reg)
            begin
                cm_veq_v   = 1'b1;
                cm_veq_col = col_reg;
            end
        end
        if (!bad_v_reg)
        begin
            if (cand_a)
            begin
                cm_bad_v   = 1'b1;
                cm_bad_col = col_reg - CW'(1);
            end
            else if (cand_b)
            begin
                cm_bad_v   = 1'b1;
                cm_bad_col = col_reg;
            end
        end
    end

    always_comb
    begin
        do_finish = (cmd == ilsp_pkg::CMD_END) || (ch == ilsp_pkg::CH_LF);
        // a lone CR right before the line end is dropped
        do_commit = held_valid_reg && (!do_finish || (held_byte_reg != ilsp_pkg::CH_CR));

        p_col     = do_commit ? cm_col     : col_reg;
        p_ws      = do_commit ? cm_ws      : ws_reg;
        p_sec     = do_commit ? cm_sec     : sec_reg;
        p_eq      = do_commit ? cm_eq      : eq_reg;
        p_rbr     = do_commit ? cm_rbr     : rbr_reg;
        p_bad_v   = do_commit ? cm_bad_v   : bad_v_reg;
        p_bad_col = do_commit ? cm_bad_col : bad_col_reg;
        p_veq_v   = do_commit ? cm_veq_v   : veq_v_reg;
        p_veq_col = do_commit ? cm_veq_col : veq_col_reg;

        fin_verdict = ilsp_pkg::VERDICT_ERROR;
        fin_err     = ilsp_pkg::ERR_NONE;
        fin_col     = '0;
        if (p_col >= CW'(MAX_COLUMNS))
        begin
            fin_err = ilsp_pkg::ERR_TOO_LONG;
        end
        else if (p_ws)
        begin
            fin_verdict = ilsp_pkg::VERDICT_BLANK;
        end
        else if (p_sec)
        begin
            if (!p_rbr)
            begin
                fin_err = ilsp_pkg::ERR_NO_RBR;
                fin_col = p_col - CW'(1);
            end
            else if (p_bad_v)
            begin
                fin_err = ilsp_pkg::ERR_BAD_SECTION;
                fin_col = p_bad_col;
            end
            else
            begin
                fin_verdict = ilsp_pkg::VERDICT_SECTION;
            end
        end
        else if (!p_eq)
        begin
            fin_err = ilsp_pkg::ERR_NO_EQ;
        end
        else if (p_bad_v)
        begin
            fin_err = ilsp_pkg::ERR_BAD_KEY;
            fin_col = p_bad_col;
        end
        else if (p_veq_v)
        begin
            fin_err = ilsp_pkg::ERR_EQ_IN_VALUE;
            fin_col = p_veq_col;
        end
        else
        begin
            fin_verdict = ilsp_pkg::VERDICT_KV;
        end
        fin_col_ext = {8'd0, fin_col};
    end

    always_comb
    begin
        commit_rec.role         = cm_role;
        commit_rec.text_byte    = held_byte_reg;
        commit_rec.verdict      = ilsp_pkg::VERDICT_BLANK;
        commit_rec.error_code   = ilsp_pkg::ERR_NONE;
        commit_rec.error_column = 8'd0;
        commit_rec.line_number  = line_index_reg;
        commit_rec.end_of_input = 1'b0;
        commit_rec.last         = !do_finish;

        fin_rec.role            = ilsp_pkg::ROLE_VERDICT;
        fin_rec.text_byte       = 8'd0;
        fin_rec.verdict         = fin_verdict;
        fin_rec.error_code      = fin_err;
        fin_rec.error_column    = fin_col_ext[7:0];
        fin_rec.line_number     = line_index_reg;
        fin_rec.end_of_input    = (cmd == ilsp_pkg::CMD_END);
        fin_rec.last            = 1'b1;

        push.rec0  = do_commit ? commit_rec : fin_rec;
        push.rec1  = fin_rec;
        push.count = (accept && !halted_reg) ?
                     ({1'b0, do_commit} + {1'b0, do_finish}) : 2'd0;
    end

    always_comb
    begin
        held_byte_next  = held_byte_reg;
        held_valid_next = held_valid_reg;
        col_next        = col_reg;
        ws_next         = ws_reg;
        sec_next        = sec_reg;
        eq_next         = eq_reg;
        rbr_next        = rbr_reg;
        bad_v_next      = bad_v_reg;
        bad_col_next    = bad_col_reg;
        veq_v_next      = veq_v_reg;
        veq_col_next    = veq_col_reg;
        line_index_next = line_index_reg;
        halted_next     = halted_reg;
        if (accept && !halted_reg)
        begin
            if (do_finish)
            begin
                held_byte_next  = 8'd0;
                held_valid_next = 1'b0;
                col_next        = '0;
                ws_next         = 1'b1;
                sec_next        = 1'b0;
                eq_next         = 1'b0;
                rbr_next        = 1'b0;
                bad_v_next      = 1'b0;
                bad_col_next    = '0;
                veq_v_next      = 1'b0;
                veq_col_next    = '0;
                halted_next     = (fin_err != ilsp_pkg::ERR_NONE);
                if (cmd == ilsp_pkg::CMD_END)
                begin
                    line_index_next = 16'd0;
                end
                else if (line_index_reg != 16'hFFFF)
                begin
                    line_index_next = line_index_reg + 16'd1;
                end
            end
            else
            begin
                held_byte_next  = ch;
                held_valid_next = 1'b1;
                col_next        = p_col;
                ws_next         = p_ws;
                sec_next        = p_sec;
                eq_next         = p_eq;
                rbr_next        = p_rbr;
                bad_v_next      = p_bad_v;
                bad_col_next    = p_bad_col;
                veq_v_next      = p_veq_v;
                veq_col_next    = p_veq_col;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_byte_reg  <= 8'd0;
            held_valid_reg <= 1'b0;
            col_reg        <= '0;
            ws_reg         <= 1'b1;
            sec_reg        <= 1'b0;
            eq_reg         <= 1'b0;
            rbr_reg        <= 1'b0;
            bad_v_reg      <= 1'b0;
            bad_col_reg    <= '0;
            veq_v_reg      <= 1'b0;
            veq_col_reg    <= '0;
            line_index_reg <= 16'd0;
            halted_reg     <= 1'b0;
        end
        else
        begin
            held_byte_reg  <= held_byte_next;
            held_valid_reg <= held_valid_next;
            col_reg        <= col_next;
            ws_reg         <= ws_next;
            sec_reg        <= sec_next;
            eq_reg         <= eq_next;
            rbr_reg        <= rbr_next;
            bad_v_reg      <= bad_v_next;
            bad_col_reg    <= bad_col_next;
            veq_v_reg      <= veq_v_next;
            veq_col_reg    <= veq_col_next;
            line_index_reg <= line_index_next;
            halted_reg     <= halted_next;
        end
    end

endmodule

// File: hw/rtl/ilsp_out_queue.sv
module ilsp_out_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  ilsp_pkg::push_t     push,
    output logic                room,
    output logic                out_valid,
    input  logic                out_ready,
    output ilsp_pkg::result_t   out_rec
);

    ilsp_pkg::result_t               entry_reg [ilsp_pkg::QUEUE_DEPTH];
    logic [ilsp_pkg::QPTR_W-1:0]     head_reg, head_next;
    logic [ilsp_pkg::QPTR_W-1:0]     tail_reg, tail_next;
    logic [ilsp_pkg::QPTR_W-1:0]     tail_plus1;
    logic [ilsp_pkg::QCNT_W-1:0]     count_reg, count_next;
    logic                            pop;

    // room for a full two-result item
    assign room       = (count_reg <= ilsp_pkg::QCNT_W'(ilsp_pkg::QUEUE_DEPTH - 2));
    assign out_valid  = (count_reg != '0);
    assign out_rec    = entry_reg[head_reg];
    assign pop        = out_valid && out_ready;
    assign tail_plus1 = tail_reg + ilsp_pkg::QPTR_W'(1);

    always_comb
    begin
        head_next  = pop ? head_reg + ilsp_pkg::QPTR_W'(1) : head_reg;
        tail_next  = tail_reg + ilsp_pkg::QPTR_W'(push.count);
        count_next = count_reg + ilsp_pkg::QCNT_W'(push.count)
                     - ilsp_pkg::QCNT_W'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push.count != 2'd0)
        begin
            entry_reg[tail_reg] <= push.rec0;
        end
        if (push.count == 2'd2)
        begin
            entry_reg[tail_plus1] <= push.rec1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
        end
    end

endmodule

// File: hw/rtl/ini_line_stream_parser_unit.sv
// channel  | dir | tdata                                   | tuser  | tlast
// s_axis   | in  | ch[7:0]                                 | cmd    | -
// m_axis   | out | text_byte, verdict, error_code,         | role   | last
//          |     | error_column, line_number, end_of_input |        |
//
// One input item per cycle while s_axis_tready is high; each item's
// results are formed in the same cycle it is accepted and land in a
// four-entry output queue. A byte yields at most one echo; a line end or
// end of input yields up to two results.
// s_axis_tready is low while the queue has fewer than two free entries.
// Asynchronous reset; no clearing pass. After an error verdict items are
// still taken but produce nothing until reset.
module ini_line_stream_parser_unit #(
    parameter int MAX_COLUMNS = 256
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // ch[7:0]
    input  logic [0:0]  s_axis_tuser,   // cmd[0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // text_byte[7:0], verdict[9:8], error_code[12:10], error_column[20:13],
    // line_number[36:21], end_of_input[37], zero[39:38]
    output logic [39:0] m_axis_tdata,
    output logic [2:0]  m_axis_tuser,   // role[2:0]
    output logic        m_axis_tlast
);

    ilsp_pkg::push_t   push;
    ilsp_pkg::result_t out_rec;
    logic              room;
    logic              accept;

    assign s_axis_tready = room;
    assign accept        = s_axis_tvalid && room;

    ilsp_core #(
        .MAX_COLUMNS (MAX_COLUMNS)
    ) u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .accept (accept),
        .cmd    (s_axis_tuser[0]),
        .ch     (s_axis_tdata),
        .push   (push)
    );

    ilsp_out_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .room      (room),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_rec   (out_rec)
    );

    assign m_axis_tdata = {2'b00, out_rec.end_of_input, out_rec.line_number,
                           out_rec.error_column, out_rec.error_code,
                           out_rec.verdict, out_rec.text_byte};
    assign m_axis_tuser = out_rec.role;
    assign m_axis_tlast = out_rec.last;

endmodule
